>>> rtl/mqtt_pkg.sv
// Shared types and constants for the MQTT inbound packet deframer.
package mqtt_pkg;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_PKTID,
        PH_PAYLOAD,
        PH_CONNACK,
        PH_IGNORE
    } t_phase;

    typedef enum logic [3:0] {
        ROLE_HEADER  = 4'd0,
        ROLE_LENGTH  = 4'd1,
        ROLE_TLEN    = 4'd2,
        ROLE_TOPIC   = 4'd3,
        ROLE_PKTID   = 4'd4,
        ROLE_PAYLOAD = 4'd5,
        ROLE_CONNACK = 4'd6,
        ROLE_IGNORED = 4'd7,
        ROLE_HALTED  = 4'd8
    } t_role;

    localparam logic [3:0] KIND_CONNACK = 4'd2;
    localparam logic [3:0] KIND_PUBLISH = 4'd3;

    typedef struct packed {
        t_role       byte_role;
        logic [7:0]  byte_value;
        logic [3:0]  packet_kind;
        logic [1:0]  service_level;
        logic        packet_last;
        logic        publish_accepted;
        logic        ack_seen;
        logic [7:0]  ack_code;
        logic        ack_refused;
        logic        length_fault;
    } t_result;

endpackage

>>> rtl/mqtt_in_if.sv
// Byte input channel: valid/ready handshake carrying one received byte.
interface mqtt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/mqtt_out_if.sv
// Result channel: valid/ready handshake carrying one tagged byte.
interface mqtt_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] byte_role;
    logic [7:0] byte_value;
    logic [3:0] packet_kind;
    logic [1:0] service_level;
    logic       packet_last;
    logic       publish_accepted;
    logic       ack_seen;
    logic [7:0] ack_code;
    logic       ack_refused;
    logic       length_fault;

    modport source (
        output valid, input ready,
        output byte_role, output byte_value, output packet_kind, output service_level,
        output packet_last, output publish_accepted, output ack_seen, output ack_code,
        output ack_refused, output length_fault
    );
    modport sink (
        input valid, output ready,
        input byte_role, input byte_value, input packet_kind, input service_level,
        input packet_last, input publish_accepted, input ack_seen, input ack_code,
        input ack_refused, input length_fault
    );
endinterface

>>> rtl/mqtt_res_reg.sv
// Result register that holds one tagged byte until the sink takes it.
module mqtt_res_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mqtt_pkg::t_result i_res,
    mqtt_out_if.source       o_res
);
    import mqtt_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can load whenever it is empty or its beat leaves this cycle.
    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.byte_role        = r_res.byte_role;
    assign o_res.byte_value       = r_res.byte_value;
    assign o_res.packet_kind      = r_res.packet_kind;
    assign o_res.service_level    = r_res.service_level;
    assign o_res.packet_last      = r_res.packet_last;
    assign o_res.publish_accepted = r_res.publish_accepted;
    assign o_res.ack_seen         = r_res.ack_seen;
    assign o_res.ack_code         = r_res.ack_code;
    assign o_res.ack_refused      = r_res.ack_refused;
    assign o_res.length_fault     = r_res.length_fault;

endmodule

>>> rtl/mqtt_inbound_packet_deframer_core.sv
// MQTT 3.1.1 inbound deframer: tags each received byte with its role in the packet.
//
//   channel  | direction | payload                                  | handshake
//   i_rx     | in        | rx_byte                                  | valid/ready
//   o_res    | out       | byte_role .. length_fault (ten fields)   | valid/ready
//
// One byte is taken per cycle when not stalled; its result is registered as it is taken.
// The parser state advances in the same cycle the byte is taken, so bytes can follow
// back to back. A byte is taken while the result register is empty or being drained.
// Synchronous active-low reset clears the parser to expect a fixed header.
// Once halted (length fault or refused CONNACK) every byte is tagged as discarded.
module mqtt_inbound_packet_deframer_core #(
    parameter int MAX_LENGTH_GROUPS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mqtt_in_if.sink     i_rx,
    mqtt_out_if.source  o_res
);
    import mqtt_pkg::*;

    localparam int LEN_W = 7 * MAX_LENGTH_GROUPS;
    localparam int GRP_W = $clog2(MAX_LENGTH_GROUPS + 1);
    localparam int CMP_W = (LEN_W > 18) ? LEN_W : 18;

    t_phase             r_phase, n_phase;
    logic [3:0]         r_kind, n_kind;
    logic [1:0]         r_level, n_level;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [LEN_W-1:0]   r_total, n_total;
    logic [GRP_W-1:0]   r_group, n_group;
    logic [15:0]        r_tsize, n_tsize;
    logic [15:0]        r_tleft, n_tleft;
    logic [7:0]         r_code, n_code;
    logic               r_halted, n_halted;

    logic [7:0]         rx_b;
    logic               accept;
    logic               res_ready;
    logic               body_byte;
    logic [CMP_W-1:0]   need;
    t_result            res;

    assign rx_b       = i_rx.rx_byte;
    assign i_rx.ready = res_ready;
    assign accept     = i_rx.valid && res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_kind   <= '0;
            r_level  <= '0;
            r_left   <= '0;
            r_total  <= '0;
            r_group  <= '0;
            r_tsize  <= '0;
            r_tleft  <= '0;
            r_code   <= '0;
            r_halted <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_level  <= n_level;
            r_left   <= n_left;
            r_total  <= n_total;
            r_group  <= n_group;
            r_tsize  <= n_tsize;
            r_tleft  <= n_tleft;
            r_code   <= n_code;
            r_halted <= n_halted;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_level   = r_level;
        n_left    = r_left;
        n_total   = r_total;
        n_group   = r_group;
        n_tsize   = r_tsize;
        n_tleft   = r_tleft;
        n_code    = r_code;
        n_halted  = r_halted;
        body_byte = 1'b0;
        need      = '0;
        res       = '0;
        res.byte_value = rx_b;
        res.byte_role  = ROLE_IGNORED;

        if (r_halted) begin
            res.byte_role = ROLE_HALTED;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    res.byte_role = ROLE_HEADER;
                    n_kind  = rx_b[7:4];
                    n_level = rx_b[2:1];
                    n_total = '0;
                    n_group = '0;
                    n_code  = '0;
                    n_tsize = '0;
                    n_tleft = '0;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    res.byte_role = ROLE_LENGTH;
                    if (r_group >= GRP_W'(MAX_LENGTH_GROUPS)) begin
                        res.length_fault = 1'b1;
                        n_halted = 1'b1;
                    end else begin
                        // Groups arrive least significant first.
                        for (int g = 0; g < MAX_LENGTH_GROUPS; g++) begin
                            if (r_group == GRP_W'(g)) begin
                                n_total[7*g +: 7] = r_total[7*g +: 7] | rx_b[6:0];
                            end
                        end
                        n_group = r_group + GRP_W'(1);
                        if (!rx_b[7]) begin
                            n_left = n_total;
                            if (n_total == '0) begin
                                res.packet_last = 1'b1;
                                res.ack_seen    = (r_kind == KIND_CONNACK);
                                n_phase = PH_HEADER;
                            end else if (r_kind == KIND_CONNACK) begin
                                n_phase = PH_CONNACK;
                            end else if (r_kind == KIND_PUBLISH) begin
                                n_phase = PH_TLEN_HI;
                            end else begin
                                n_phase = PH_IGNORE;
                            end
                        end
                    end
                end
                PH_CONNACK: begin
                    res.byte_role = ROLE_CONNACK;
                    body_byte = 1'b1;
                    // The return code is the second body byte.
                    if ({1'b0, r_left} + (LEN_W+1)'(1) == {1'b0, r_total}) begin
                        n_code = rx_b;
                    end
                end
                PH_TLEN_HI: begin
                    res.byte_role = ROLE_TLEN;
                    body_byte = 1'b1;
                    n_tsize = {rx_b, 8'd0};
                    n_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    res.byte_role = ROLE_TLEN;
                    body_byte = 1'b1;
                    n_tsize = {r_tsize[15:8], rx_b};
                    need = CMP_W'(n_tsize) + CMP_W'((r_level != 2'd0) ? 4 : 2);
                    if (need <= CMP_W'(r_total)) begin
                        res.publish_accepted = 1'b1;
                        if (n_tsize != 16'd0) begin
                            n_tleft = n_tsize;
                            n_phase = PH_TOPIC;
                        end else if (r_level != 2'd0) begin
                            n_tleft = 16'd2;
                            n_phase = PH_PKTID;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_phase = PH_IGNORE;
                    end
                end
                PH_TOPIC: begin
                    res.byte_role = ROLE_TOPIC;
                    body_byte = 1'b1;
                    n_tleft = (r_tleft != 16'd0) ? r_tleft - 16'd1 : 16'd0;
                    if (n_tleft == 16'd0) begin
                        if (r_level != 2'd0) begin
                            n_tleft = 16'd2;
                            n_phase = PH_PKTID;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PKTID: begin
                    res.byte_role = ROLE_PKTID;
                    body_byte = 1'b1;
                    n_tleft = (r_tleft != 16'd0) ? r_tleft - 16'd1 : 16'd0;
                    if (n_tleft == 16'd0) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res.byte_role = ROLE_PAYLOAD;
                    body_byte = 1'b1;
                end
                default: begin
                    res.byte_role = ROLE_IGNORED;
                    body_byte = 1'b1;
                end
            endcase

            if (body_byte) begin
                n_left = (r_left != '0) ? r_left - LEN_W'(1) : '0;
                if (n_left == '0) begin
                    res.packet_last = 1'b1;
                    if (r_kind == KIND_CONNACK) begin
                        res.ack_seen = 1'b1;
                        res.ack_code = n_code;
                        if (n_code != 8'd0) begin
                            res.ack_refused = 1'b1;
                            n_halted = 1'b1;
                        end
                    end
                    n_phase = PH_HEADER;
                end
            end

            res.packet_kind   = n_kind;
            res.service_level = n_level;
        end
    end

    mqtt_res_reg u_res_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_res   (o_res)
    );

endmodule

>>> tb/tb_mqtt_inbound_packet_deframer_core.sv
// Self-checking testbench for the MQTT inbound deframer against a tag scoreboard.
`timescale 1ns / 100ps

module tb_mqtt_inbound_packet_deframer_core;
    import mqtt_pkg::*;

    localparam int MAX_GROUPS = 3;
    localparam int LONG_HOLD = 300;

    // Tracks the parser state of the stream and the tags it must produce.
    class tag_scoreboard;
        t_phase      cur_phase;
        logic [3:0]  cur_kind;
        logic [1:0]  cur_qos;
        logic [20:0] body_left;
        logic [20:0] body_size;
        logic [1:0]  len_groups;
        logic [15:0] topic_len;
        logic [15:0] topic_left;
        logic [7:0]  ack_rc;
        bit          is_halted;
        t_result     pending_tags[$];
        int          errors;
        int          checked;

        function new();
            cur_phase = PH_HEADER;
            cur_kind = '0;
            cur_qos = '0;
            body_left = '0;
            body_size = '0;
            len_groups = '0;
            topic_len = '0;
            topic_left = '0;
            ack_rc = '0;
            is_halted = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function string fmt(t_result r);
            return $sformatf({"role=%0d val=%02h kind=%0d qos=%0d last=%0b acc=%0b",
                              " seen=%0b code=%02h ref=%0b fault=%0b"},
                r.byte_role, r.byte_value, r.packet_kind, r.service_level, r.packet_last,
                r.publish_accepted, r.ack_seen, r.ack_code, r.ack_refused, r.length_fault);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            t_result     r;
            logic        body_beat;
            int unsigned need;
            r = '0;
            r.byte_value = b;
            r.byte_role = ROLE_IGNORED;
            body_beat = 1'b0;
            if (is_halted) begin
                r.byte_role = ROLE_HALTED;
                pending_tags.push_back(r);
                return;
            end
            case (cur_phase)
                PH_HEADER: begin
                    r.byte_role = ROLE_HEADER;
                    cur_kind = b[7:4];
                    cur_qos = b[2:1];
                    body_size = '0;
                    len_groups = '0;
                    ack_rc = '0;
                    topic_len = '0;
                    topic_left = '0;
                    cur_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    r.byte_role = ROLE_LENGTH;
                    if (int'(len_groups) >= MAX_GROUPS) begin
                        r.length_fault = 1'b1;
                        is_halted = 1'b1;
                    end else begin
                        body_size = body_size | (21'(b[6:0]) << (7 * len_groups));
                        len_groups = len_groups + 1'b1;
                        if (!b[7]) begin
                            body_left = body_size;
                            if (body_size == 0) begin
                                r.packet_last = 1'b1;
                                if (cur_kind == KIND_CONNACK) r.ack_seen = 1'b1;
                                cur_phase = PH_HEADER;
                            end else if (cur_kind == KIND_CONNACK) begin
                                cur_phase = PH_CONNACK;
                            end else if (cur_kind == KIND_PUBLISH) begin
                                cur_phase = PH_TLEN_HI;
                            end else begin
                                cur_phase = PH_IGNORE;
                            end
                        end
                    end
                end
                PH_CONNACK: begin
                    r.byte_role = ROLE_CONNACK;
                    body_beat = 1'b1;
                    // The return code is the second body byte.
                    if (body_size - body_left == 1) ack_rc = b;
                end
                PH_TLEN_HI: begin
                    r.byte_role = ROLE_TLEN;
                    body_beat = 1'b1;
                    topic_len = {b, 8'h00};
                    cur_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    r.byte_role = ROLE_TLEN;
                    body_beat = 1'b1;
                    topic_len[7:0] = b;
                    need = 2 + topic_len + ((cur_qos != 0) ? 2 : 0);
                    if (need <= body_size) begin
                        r.publish_accepted = 1'b1;
                        if (topic_len != 0) begin
                            topic_left = topic_len;
                            cur_phase = PH_TOPIC;
                        end else if (cur_qos != 0) begin
                            topic_left = 16'd2;
                            cur_phase = PH_PKTID;
                        end else begin
                            cur_phase = PH_PAYLOAD;
                        end
                    end else begin
                        cur_phase = PH_IGNORE;
                    end
                end
                PH_TOPIC: begin
                    r.byte_role = ROLE_TOPIC;
                    body_beat = 1'b1;
                    if (topic_left > 0) topic_left = topic_left - 1'b1;
                    if (topic_left == 0) begin
                        if (cur_qos != 0) begin
                            topic_left = 16'd2;
                            cur_phase = PH_PKTID;
                        end else begin
                            cur_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PKTID: begin
                    r.byte_role = ROLE_PKTID;
                    body_beat = 1'b1;
                    if (topic_left > 0) topic_left = topic_left - 1'b1;
                    if (topic_left == 0) cur_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    r.byte_role = ROLE_PAYLOAD;
                    body_beat = 1'b1;
                end
                default: begin
                    r.byte_role = ROLE_IGNORED;
                    body_beat = 1'b1;
                end
            endcase
            if (body_beat) begin
                if (body_left > 0) body_left = body_left - 1'b1;
                if (body_left == 0) begin
                    r.packet_last = 1'b1;
                    if (cur_kind == KIND_CONNACK) begin
                        r.ack_seen = 1'b1;
                        r.ack_code = ack_rc;
                        if (ack_rc != 0) begin
                            r.ack_refused = 1'b1;
                            is_halted = 1'b1;
                        end
                    end
                    cur_phase = PH_HEADER;
                end
            end
            r.packet_kind = cur_kind;
            r.service_level = cur_qos;
            pending_tags.push_back(r);
        endfunction

        function void check_tag(t_result got);
            t_result want;
            if (pending_tags.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected tag beat %0d: got %s", checked, fmt(got));
            end else begin
                want = pending_tags.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("tag mismatch beat %0d: expected %s, got %s",
                            checked, fmt(want), fmt(got));
                end
            end
            checked++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    int   stall_left = 0;
    int   sent_bytes = 0;
    int   mark;
    t_result seen_tag;
    tag_scoreboard sb = new();

    mqtt_in_if  rx_if();
    mqtt_out_if res_if();

    mqtt_inbound_packet_deframer_core #(.MAX_LENGTH_GROUPS(MAX_GROUPS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one byte and returns at the edge that takes it.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        sb.note_rx_byte(b);
        sent_bytes++;
    endtask

    // Sends a whole control packet; pad adds non-minimal zero length groups.
    task automatic send_frame(input logic [7:0] hdr, input int unsigned body_len,
                              input int pad, input logic [15:0] tlen);
        int unsigned groups;
        int unsigned rest;
        int unsigned i;
        logic [7:0]  b;
        send_byte(hdr);
        groups = 1;
        rest = body_len >> 7;
        while (rest != 0) begin
            groups++;
            rest = rest >> 7;
        end
        groups = groups + pad;
        if (groups > MAX_GROUPS) groups = MAX_GROUPS;
        for (i = 0; i < groups; i++) begin
            b[6:0] = 7'(body_len >> (7 * i));
            b[7] = (i + 1 < groups);
            send_byte(b);
        end
        for (i = 0; i < body_len; i++) begin
            b = 8'($urandom);
            if (hdr[7:4] == KIND_PUBLISH && i == 0) b = tlen[15:8];
            else if (hdr[7:4] == KIND_PUBLISH && i == 1) b = tlen[7:0];
            else if (hdr[7:4] == KIND_CONNACK && i == 1) b = 8'h00;
            send_byte(b);
        end
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned qos;
        int unsigned tl;
        int unsigned body;
        int unsigned need;
        int          pad;
        logic [3:0]  kind;
        logic [7:0]  hdr;
        pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        pick = $urandom_range(0, 99);
        tl = 0;
        if (pick < 45) begin
            qos = $urandom_range(0, 3);
            tl = $urandom_range(0, 6);
            need = 2 + tl + ((qos != 0) ? 2 : 0);
            body = need + $urandom_range(0, 8);
            case ($urandom_range(0, 9))
                0: body = $urandom_range(0, need - 1);
                1: tl = $urandom_range(0, 65535);
                2: body = $urandom_range(128, 200);
                default: ;
            endcase
            hdr = {KIND_PUBLISH, 1'($urandom), 2'(qos), 1'($urandom)};
        end else if (pick < 60) begin
            body = $urandom_range(0, 4);
            hdr = {KIND_CONNACK, 4'($urandom)};
        end else begin
            kind = 4'($urandom);
            while (kind == KIND_CONNACK || kind == KIND_PUBLISH) kind = 4'($urandom);
            body = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 160)
                                                 : $urandom_range(0, 6);
            hdr = {kind, 4'($urandom)};
        end
        send_frame(hdr, body, pad, 16'(tl));
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen_tag.byte_role = t_role'(res_if.byte_role);
            seen_tag.byte_value = res_if.byte_value;
            seen_tag.packet_kind = res_if.packet_kind;
            seen_tag.service_level = res_if.service_level;
            seen_tag.packet_last = res_if.packet_last;
            seen_tag.publish_accepted = res_if.publish_accepted;
            seen_tag.ack_seen = res_if.ack_seen;
            seen_tag.ack_code = res_if.ack_code;
            seen_tag.ack_refused = res_if.ack_refused;
            seen_tag.length_fault = res_if.length_fault;
            sb.check_tag(seen_tag);
        end
    end

    initial begin
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // CONNACK with an empty body spelled in three length groups.
        send_frame({KIND_CONNACK, 4'h0}, 0, 2, 16'h0000);
        send_frame({KIND_CONNACK, 4'h0}, 2, 0, 16'h0000);
        // PUBLISH whose body ends on its only topic-length byte.
        send_frame(8'h30, 1, 0, 16'h0000);
        // QoS 1 PUBLISH that exactly fills its body, ending on the packet id.
        send_frame(8'h32, 5, 0, 16'h0001);
        // Topic length far beyond the body: the rest is ignored.
        send_frame(8'h30, 3, 0, 16'hFFFF);
        send_frame(8'hFF, 1, 0, 16'h0000);

        // The receiver holds off while the sender keeps offering.
        hold_req = 1'b1;
        mark = sent_bytes;
        while (sent_bytes - mark < 200) begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_frame();
        end
        idle_on = 1'b1;
        send_frame(8'h3B, 140, 0, 16'h0080);
        mark = sent_bytes;
        while (sent_bytes - mark < 120) begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_frame();
        end

        idle_on = 1'b0;
        repeat (8) send_random_frame();
        if ($urandom_range(0, 1) == 1) begin
            // Fourth length byte after three continuation groups.
            send_byte(8'($urandom));
            repeat (3) send_byte(8'h80 | 8'($urandom_range(0, 127)));
            send_byte(8'($urandom));
        end else begin
            send_byte({KIND_CONNACK, 4'($urandom)});
            mark = $urandom_range(2, 4);
            send_byte(8'(mark));
            send_byte(8'($urandom));
            send_byte(8'($urandom_range(1, 255)));
            repeat (mark - 2) send_byte(8'($urandom));
        end
        repeat (16) send_byte(8'($urandom));
        @(negedge i_clk);
        rx_if.valid <= 1'b0;

        while (sb.pending_tags.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_tags.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
